// ----- hw/rtl/weighted_centroid_3d_defines.svh -----
// Assertion macros for the weighted centroid block.
`ifndef WEIGHTED_CENTROID_3D_DEFINES_SVH
`define WEIGHTED_CENTROID_3D_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define WC3D_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wc3d check failed");

`define WC3D_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wc3d check failed");

`else

`define WC3D_ASSERT_IMP(label, ante, cons)

`define WC3D_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hw/rtl/wc3d_pkg.sv -----
package wc3d_pkg;

   localparam int DEFAULT_MAX_POINTS = 1024;

   localparam int COORD_W    = 32;
   localparam int WEIGHT_W   = 16;
   localparam int MULT_W     = WEIGHT_W + 1;
   localparam int PROD_W     = COORD_W + MULT_W + 1;
   localparam int SUM_W      = 64;
   localparam int WT_TOTAL_W = 26;
   localparam int PC_W       = 11;
   localparam int DATA_W     = 112;
   localparam int RSP_PAD_W  = DATA_W - 3 * COORD_W - PC_W;
   localparam int NUM_AXES   = 3;
   localparam int STEP_W     = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [MULT_W-1:0] WEIGHT_ONE = MULT_W'(256);
   localparam logic [MULT_W-1:0] UNIT_MULT  = MULT_W'(1);

   localparam logic [SUM_W-1:0]   NEG_LIMIT = SUM_W'(64'h0000_0000_8000_0000);
   localparam logic [SUM_W-1:0]   POS_LIMIT = SUM_W'(64'h0000_0000_7FFF_FFFF);
   localparam logic [COORD_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

   localparam logic [0:0] REG_WEIGHTING = 1'b0;

   typedef enum logic {
      KIND_POINT = 1'b0,
      KIND_DERIV = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                          kind;
      logic [NUM_AXES-1:0][SUM_W-1:0]    num;
      logic [WT_TOTAL_W-1:0]             den;
      logic [PC_W-1:0]                   pc;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hw/rtl/wc3d_queue.sv -----
module wc3d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wc3d_pkg::job_type  push_job,
   input  logic               pop,
   output wc3d_pkg::job_type  head_job,
   output wc3d_pkg::queue_stat_type stat
);
   import wc3d_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/wc3d_front.sv -----
module wc3d_front #(
   parameter int MAX_POINTS = wc3d_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          weighting_enabled,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wc3d_pkg::DATA_W-1:0]   req_tdata,
   input  logic                          req_tuser,
   input  logic                          req_tlast,
   output logic                          job_push,
   output wc3d_pkg::job_type             job,
   input  wc3d_pkg::queue_stat_type      q_stat
);
   import wc3d_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_POINTS);

   function automatic logic [SUM_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
      sext_prod = {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   logic                              s1_valid_ff, s1_valid_in;
   kind_type                          s1_kind_ff;
   logic                              s1_last_ff;
   logic [MULT_W-1:0]                 s1_w_ff;
   logic signed [PROD_W-1:0]          s1_prod_ff [NUM_AXES];

   logic [NUM_AXES-1:0][SUM_W-1:0]    sum_ff, sum_in, sum_add;
   logic [WT_TOTAL_W-1:0]             wt_ff, wt_in, wt_add;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in, cnt_add;
   logic [CNT_W-1:0]                  set_cnt_ff, set_cnt_in;

   kind_type                          in_kind;
   logic [MULT_W-1:0]                 in_mult;
   logic signed [COORD_W-1:0]         in_coord [NUM_AXES];
   logic                              accept, accum, s1_push, s1_go;

   assign in_kind = kind_type'(req_tuser);
   assign in_mult = (in_kind == KIND_DERIV) ? UNIT_MULT :
                    (weighting_enabled ? MULT_W'(req_tdata[3*COORD_W +: WEIGHT_W]) : WEIGHT_ONE);

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         in_coord[i] = signed'(req_tdata[i*COORD_W +: COORD_W]);
      end
   end

   assign accum   = (s1_kind_ff == KIND_POINT) && (cnt_ff < CNT_LIMIT);
   assign s1_push = s1_valid_ff && ((s1_kind_ff == KIND_POINT) ? s1_last_ff
                                                               : (set_cnt_ff != '0));
   assign s1_go   = s1_valid_ff && (!s1_push || !q_stat.full);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept  = req_tvalid && req_tready;
   assign job_push = s1_go && s1_push;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sum_add[i] = sum_ff[i] + (accum ? sext_prod(s1_prod_ff[i]) : '0);
      end
      wt_add  = wt_ff + (accum ? WT_TOTAL_W'(s1_w_ff) : '0);
      cnt_add = cnt_ff + (accum ? CNT_W'(1) : '0);

      job.kind = s1_kind_ff;
      if (s1_kind_ff == KIND_POINT) begin
         job.num = sum_add;
         job.den = wt_add;
         job.pc  = PC_W'(cnt_add);
      end else begin
         for (int i = 0; i < NUM_AXES; i++) begin
            job.num[i] = sext_prod(s1_prod_ff[i]);
         end
         job.den = WT_TOTAL_W'(set_cnt_ff);
         job.pc  = PC_W'(set_cnt_ff);
      end

      sum_in     = sum_ff;
      wt_in      = wt_ff;
      cnt_in     = cnt_ff;
      set_cnt_in = set_cnt_ff;
      if (s1_go && (s1_kind_ff == KIND_POINT)) begin
         if (s1_last_ff) begin
            sum_in     = '0;
            wt_in      = '0;
            cnt_in     = '0;
            set_cnt_in = cnt_add;
         end else begin
            sum_in = sum_add;
            wt_in  = wt_add;
            cnt_in = cnt_add;
         end
      end

      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         wt_ff       <= '0;
         cnt_ff      <= '0;
         set_cnt_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sum_ff      <= sum_in;
         wt_ff       <= wt_in;
         cnt_ff      <= cnt_in;
         set_cnt_ff  <= set_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= in_kind;
         s1_last_ff <= req_tlast;
         s1_w_ff    <= in_mult;
         for (int i = 0; i < NUM_AXES; i++) begin
            s1_prod_ff[i] <= in_coord[i] * signed'({1'b0, in_mult});
         end
      end
   end

endmodule

// ----- hw/rtl/wc3d_divider.sv -----
module wc3d_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  wc3d_pkg::job_type             job,
   input  wc3d_pkg::queue_stat_type      q_stat,
   output logic                          job_pop,
   output wc3d_pkg::div_stat_type        div_stat,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [wc3d_pkg::DATA_W-1:0]   rsp_tdata,  // out_x, out_y, out_z, point_count
   output logic                          rsp_tuser   // result_kind
);
   import wc3d_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [COORD_W-1:0] sat_quot(input logic [SUM_W-1:0] q, input logic neg);
      logic [SUM_W-1:0] qc;
      if (neg) begin
         qc = (q > NEG_LIMIT) ? NEG_LIMIT : q;
         sat_quot = COORD_W'(0) - qc[COORD_W-1:0];
      end else begin
         sat_quot = (q > POS_LIMIT) ? POS_MAX : q[COORD_W-1:0];
      end
   endfunction

   state_type                      state_ff, state_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic [NUM_AXES-1:0][SUM_W-1:0] dvd_ff, dvd_in;
   logic [NUM_AXES-1:0][WT_TOTAL_W-1:0] rem_ff, rem_in;
   logic [NUM_AXES-1:0]            neg_ff, neg_in;
   logic [WT_TOTAL_W-1:0]          den_ff, den_in;
   kind_type                       kind_ff, kind_in;
   logic [PC_W-1:0]                pc_ff, pc_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   kind_type                       rsp_kind_ff, rsp_kind_in;
   logic [NUM_AXES-1:0][COORD_W-1:0] rsp_val_ff, rsp_val_in;
   logic [PC_W-1:0]                rsp_pc_ff, rsp_pc_in;

   logic [WT_TOTAL_W:0]            rem_sh [NUM_AXES];
   logic [WT_TOTAL_W:0]            rem_sub [NUM_AXES];
   logic                           out_free;

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign job_pop       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign div_stat.busy = (state_ff == ST_DIV);
   assign div_stat.done = (state_ff == ST_DONE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_pc_ff, rsp_val_ff[2], rsp_val_ff[1], rsp_val_ff[0]};

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      kind_in      = kind_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_pc_in    = rsp_pc_ff;

      for (int i = 0; i < NUM_AXES; i++) begin
         rem_sh[i]  = {rem_ff[i], dvd_ff[i][SUM_W-1]};
         rem_sub[i] = rem_sh[i] - {1'b0, den_ff};
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  neg_in[i] = job.num[i][SUM_W-1];
                  dvd_in[i] = job.num[i][SUM_W-1] ? SUM_W'(0) - job.num[i] : job.num[i];
               end
               rem_in   = '0;
               den_in   = job.den;
               kind_in  = job.kind;
               pc_in    = job.pc;
               step_in  = STEP_W'(SUM_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (rem_sh[i] >= {1'b0, den_ff}) begin
                  rem_in[i] = rem_sub[i][WT_TOTAL_W-1:0];
                  dvd_in[i] = {dvd_ff[i][SUM_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = rem_sh[i][WT_TOTAL_W-1:0];
                  dvd_in[i] = {dvd_ff[i][SUM_W-2:0], 1'b0};
               end
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_pc_in    = pc_ff;
               for (int i = 0; i < NUM_AXES; i++) begin
                  rsp_val_in[i] = (den_ff == '0) ? '0 : sat_quot(dvd_ff[i], neg_ff[i]);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      den_ff      <= den_in;
      kind_ff     <= kind_in;
      pc_ff       <= pc_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_pc_ff   <= rsp_pc_in;
   end

endmodule

// ----- hw/rtl/weighted_centroid_3d.sv -----
// Weighted 3-D centroid. Point samples are taken one per cycle and folded
// into 64-bit weighted sums, a 26-bit weight total and a point count. A
// sample marked last, and a derivative item when the last set was not
// empty, each queue one divide job (two-entry queue). The shared radix-2
// divider runs the three axes side by side; each job holds it while it is
// loaded, for 64 steps, and until its result is handed off, and jobs
// behind it wait in turn. The input stalls only while a job must enter a
// full queue. A zero weight total gives a zero center.
`include "weighted_centroid_3d_defines.svh"

module weighted_centroid_3d #(
   parameter int MAX_POINTS = wc3d_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wc3d_pkg::DATA_W-1:0]       req_tdata,  // x_val, y_val, z_val, weight
   input  logic                              req_tuser,  // kind
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wc3d_pkg::DATA_W-1:0]       rsp_tdata,  // out_x, out_y, out_z, point_count
   output logic                              rsp_tuser,  // result_kind
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wc3d_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wc3d_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wc3d_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wc3d_pkg::*;

   logic            weighting_ff, weighting_in;
   logic [0:0]      csr_index;
   logic            csr_wr;
   logic            job_push, job_pop;
   job_type         push_job, head_job;
   queue_stat_type  q_stat;
   div_stat_type    div_stat;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_WEIGHTING) ? CSR_DATA_W'(weighting_ff) : '0;

   always_comb begin
      weighting_in = weighting_ff;
      if (csr_wr && (csr_index == REG_WEIGHTING)) begin
         weighting_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weighting_ff <= 1'b0;
      end else begin
         weighting_ff <= weighting_in;
      end
   end

   wc3d_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .weighting_enabled (weighting_ff),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .req_tlast         (req_tlast),
      .job_push          (job_push),
      .job               (push_job),
      .q_stat            (q_stat)
   );

   wc3d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   wc3d_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .job        (head_job),
      .q_stat     (q_stat),
      .job_pop    (job_pop),
      .div_stat   (div_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `WC3D_ASSERT_IMP(a_push_not_full, job_push, !q_stat.full)
   `WC3D_ASSERT_IMP(a_pop_not_empty, job_pop, !q_stat.empty)
   `WC3D_ASSERT_IMP(a_stall_only_full, !req_tready, q_stat.full)
   `WC3D_ASSERT_NXT(a_pop_starts_div, job_pop, div_stat.busy && !div_stat.done)

endmodule
